// ----- design/dabp_pkg.sv -----
// package for the depth aware blur pixel block: request and result structs,
// configuration register indexes, path codes and fixed-point constants
// no dependencies
`timescale 1ns / 1ps

package dabp_pkg;

  localparam int unsigned PixelW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned WinCount = 9;
  localparam int unsigned ChanCount = 3;

  // sum widths: eight depths, nine channel bytes
  localparam int unsigned DsumW = 11;
  localparam int unsigned CsumW = 12;
  localparam int unsigned CntW  = 4;
  localparam int unsigned NumW  = 15;

  localparam logic [7:0]  DofFull     = 8'd127;
  localparam logic [7:0]  DefaultTol  = 8'd10;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;
  // floor(x / 9) = (x * 7282) >> 16 for x below 2296
  localparam logic [12:0] RecipNine   = 13'd7282;
  localparam int unsigned RecipNineSh = 16;
  // floor(x / 127) = (x * 33027) >> 22 for x below 32386
  localparam logic [15:0] Recip127    = 16'd33027;
  localparam int unsigned Recip127Sh  = 22;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLUR_ENABLE = 2'd0,
    CFG_DEPTH_TOL   = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PATH_EMPTY  = 2'd0,
    PATH_BLEND  = 2'd1,
    PATH_SHARP  = 2'd2,
    PATH_BYPASS = 2'd3
  } path_e;

  typedef struct packed {
    logic [PixelW-1:0] center_pixel;
    logic [PixelW-1:0] near_right;
    logic [PixelW-1:0] near_left;
    logic [PixelW-1:0] near_below;
    logic [PixelW-1:0] near_above;
    logic [PixelW-1:0] far_below_right;
    logic [PixelW-1:0] far_below_left;
    logic [PixelW-1:0] far_above_right;
    logic [PixelW-1:0] far_above_left;
  } req_t;

  typedef struct packed {
    logic [PixelW-1:0] out_pixel;
    logic [1:0]        path_taken;
  } res_t;

endpackage

// ----- design/depth_aware_blur_pixel.sv -----
// depth aware 3x3 blur for one pixel window, four register stages
// depends on dabp_pkg
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------
//  request | in        | in_valid_i/in_ready_o | in_data_i (req_t)
//  result  | out       | out_valid_o/out_ready_i | out_data_o (res_t)
//  config  | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// one request per cycle while the output is not stalled
// stage 1 sums depths and channels, stage 2 divides by nine and tests the
// depth window, stage 3 forms the blend numerator, stage 4 divides by 127
// a stall at the output backs up only through stages that hold a request
// reset clears the valid bits, blur_enable to 0 and depth_tolerance to 10
`timescale 1ns / 1ps

module depth_aware_blur_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dabp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dabp_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dabp_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dabp_pkg::res_t                out_data_o
);
  import dabp_pkg::*;

  typedef struct packed {
    logic [PixelW-1:0]                  center;
    logic [DsumW-1:0]                   dsum;
    logic [CntW-1:0]                    cnt;
    logic [ChanCount-1:0][CsumW-1:0]    csum;
    path_e                              path;
  } s1_t;

  typedef struct packed {
    logic [PixelW-1:0]                  center;
    logic [ChanCount-1:0][7:0]          mean;
    logic [6:0]                         w;
    path_e                              path;
  } s2_t;

  typedef struct packed {
    logic [PixelW-1:0]                  center;
    logic [ChanCount-1:0][NumW-1:0]     num;
    path_e                              path;
  } s3_t;

  logic       blur_en_q;
  logic [7:0] tol_q;

  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdyo;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  res_t out_d, out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blur_en_q <= 1'b0;
      tol_q     <= DefaultTol;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BLUR_ENABLE: blur_en_q <= cfg_data_i[0];
        CFG_DEPTH_TOL:   tol_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage takes new data when it is empty or its contents move on
  assign rdyo       = !vo_q || out_ready_i;
  assign rdy3       = !v3_q || rdyo;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: neighbour count, depth sum, channel sums
  always_comb begin
    logic [WinCount-1:0][PixelW-1:0] win;
    logic                            any;
    win = {in_data_i.far_above_left, in_data_i.far_above_right,
           in_data_i.far_below_left, in_data_i.far_below_right,
           in_data_i.near_above, in_data_i.near_below,
           in_data_i.near_left, in_data_i.near_right,
           in_data_i.center_pixel};
    any       = 1'b0;
    s1_d.dsum = '0;
    s1_d.cnt  = '0;
    s1_d.csum = '0;
    for (int i = 0; i < WinCount; i++) begin
      any = any || (win[i] != '0);
      if (i > 0) begin
        s1_d.dsum = s1_d.dsum + DsumW'(win[i][31:24]);
        s1_d.cnt  = s1_d.cnt + CntW'(win[i] != '0);
      end
      for (int k = 0; k < ChanCount; k++) begin
        s1_d.csum[k] = s1_d.csum[k] + CsumW'(win[i][8*k +: 8]);
      end
    end
    s1_d.center = in_data_i.center_pixel;
    if (!blur_en_q) begin
      s1_d.path = PATH_BYPASS;
    end else if (!any) begin
      s1_d.path = PATH_EMPTY;
    end else begin
      s1_d.path = PATH_BLEND;
    end
  end

  // stage 2: means by nine, depth window test without a divider:
  // d - tol <= floor(dsum / n) <= d + tol  <=>  (d-tol)*n <= dsum < (d+tol+1)*n
  always_comb begin
    logic [7:0]  depth;
    logic [7:0]  lo;
    logic [11:0] lo_prod;
    logic [8:0]  hi;
    logic [12:0] hi_prod;
    logic        lo_ok, hi_ok;
    logic [24:0] mprod;
    depth   = s1_q.center[31:24];
    lo      = (depth > tol_q) ? (depth - tol_q) : 8'd0;
    lo_prod = 12'(lo) * 12'(s1_q.cnt);
    hi      = 9'(depth) + 9'(tol_q) + 9'd1;
    hi_prod = 13'(hi) * 13'(s1_q.cnt);
    lo_ok   = (12'(s1_q.dsum) >= lo_prod);
    hi_ok   = (s1_q.cnt == '0) || (13'(s1_q.dsum) < hi_prod);
    for (int k = 0; k < ChanCount; k++) begin
      mprod        = 25'(s1_q.csum[k]) * 25'(RecipNine);
      s2_d.mean[k] = mprod[RecipNineSh +: 8];
    end
    s2_d.w      = (depth < DofFull) ? 7'(DofFull - depth) : 7'd0;
    s2_d.center = s1_q.center;
    s2_d.path   = s1_q.path;
    if (s1_q.path == PATH_BLEND && !(lo_ok && hi_ok)) begin
      s2_d.path = PATH_SHARP;
    end
  end

  // stage 3: blend numerator w*c + (127-w)*mean
  always_comb begin
    logic [6:0] wc;
    wc = 7'(DofFull) - s2_q.w;
    for (int k = 0; k < ChanCount; k++) begin
      s3_d.num[k] = NumW'(s2_q.w) * NumW'(s2_q.center[8*k +: 8])
                  + NumW'(wc) * NumW'(s2_q.mean[k]);
    end
    s3_d.center = s2_q.center;
    s3_d.path   = s2_q.path;
  end

  // stage 4: divide by 127 and assemble the result word
  always_comb begin
    logic [30:0]               dprod;
    logic [ChanCount-1:0][7:0] blend;
    for (int k = 0; k < ChanCount; k++) begin
      dprod    = 31'(s3_q.num[k]) * 31'(Recip127);
      blend[k] = dprod[Recip127Sh +: 8];
    end
    out_d.path_taken = s3_q.path;
    case (s3_q.path)
      PATH_EMPTY:  out_d.out_pixel = '0;
      PATH_BLEND:  out_d.out_pixel = {AlphaOpaque, blend};
      PATH_SHARP:  out_d.out_pixel = {AlphaOpaque, s3_q.center[23:0]};
      default:     out_d.out_pixel = s3_q.center;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
    if (rdyo && v3_q)       out_q <= out_d;
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

// ----- dv/tb_depth_aware_blur_pixel.sv -----
// testbench for depth_aware_blur_pixel: directed and random pixel windows are checked
// against a built-in predictor of the depth-of-field blend, with random idling on both sides
// depends on dabp_pkg and the block itself
`timescale 1ns / 1ps

module tb_depth_aware_blur_pixel;
  import dabp_pkg::*;

  localparam int unsigned PipeLat    = 4;
  localparam int unsigned StallLimit = 1000;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareB = 2'd3;
  localparam logic [CfgW-1:0]    EnableOn     = 8'h01;
  localparam logic [CfgW-1:0]    EnableOffHi  = 8'hFE;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgW-1:0]      cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  req_t                 in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  res_t                 out_data_o;

  // predictor copy of the registers
  bit                   blur_on;
  logic [7:0]           tol_reg;

  res_t                 pending_pixels[$];
  int unsigned          windows_sent;
  int unsigned          results_checked;
  int unsigned          errors_seen;
  int unsigned          path_hits[4];
  int unsigned          idle_cycles;
  bit                   sender_calm;
  bit                   receiver_calm;

  depth_aware_blur_pixel DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic res_t predict_pixel(req_t win);
    logic [PixelW-1:0] px [WinCount];
    res_t        r;
    int unsigned n;
    int unsigned dsum;
    int unsigned depth;
    int unsigned w;
    int unsigned s;
    int unsigned mean;
    int unsigned v;
    int          dd;
    bit          any;
    for (int i = 0; i < WinCount; i++) begin
      px[i] = win[PixelW*(WinCount-1-i) +: PixelW];
    end
    if (!blur_on) begin
      r.out_pixel  = win.center_pixel;
      r.path_taken = PATH_BYPASS;
      return r;
    end
    any = 1'b0;
    for (int i = 0; i < WinCount; i++) begin
      if (px[i] != '0) any = 1'b1;
    end
    if (!any) begin
      r.out_pixel  = '0;
      r.path_taken = PATH_EMPTY;
      return r;
    end
    n    = 0;
    dsum = 0;
    for (int i = 1; i < WinCount; i++) begin
      if (px[i] != '0) n++;
      dsum += px[i][31:24];
    end
    depth = px[0][31:24];
    dd    = (n != 0) ? int'(dsum / n) - int'(depth) : 0;
    if (dd >= -int'(tol_reg) && dd <= int'(tol_reg)) begin
      w = (depth < DofFull) ? DofFull - depth : 0;
      r.out_pixel[31:24] = AlphaOpaque;
      for (int ch = 0; ch < ChanCount; ch++) begin
        s = 0;
        for (int i = 0; i < WinCount; i++) s += px[i][8*ch +: 8];
        mean = s / WinCount;
        v    = (w * px[0][8*ch +: 8] + (DofFull - w) * mean) / DofFull;
        r.out_pixel[8*ch +: 8] = v[7:0];
      end
      r.path_taken = PATH_BLEND;
    end else begin
      r.out_pixel  = {AlphaOpaque, px[0][23:0]};
      r.path_taken = PATH_SHARP;
    end
    return r;
  endfunction

  // word with the given depth, clamped, and a random colour that is never zero
  function automatic logic [PixelW-1:0] pixel_at_depth(int dep);
    logic [7:0] d;
    d = (dep < 0) ? 8'd0 : (dep > 255) ? 8'd255 : 8'(dep);
    return {d, 24'($urandom_range(1, 24'hFFFFFF))};
  endfunction

  // centre word, first `zeros` neighbours zero, the rest at one depth
  function automatic req_t window_of(logic [PixelW-1:0] ctr, int nb_depth, int zeros);
    req_t win;
    win.center_pixel = ctr;
    for (int i = 1; i < WinCount; i++) begin
      win[PixelW*(WinCount-1-i) +: PixelW] = (i <= zeros) ? '0 : pixel_at_depth(nb_depth);
    end
    return win;
  endfunction

  // mostly windows whose neighbour depths sit near the centre, plus noise,
  // sparse windows and empty ones
  function automatic req_t random_window(int spread);
    req_t             win;
    int               kind;
    int               dep;
    logic [PixelW-1:0] word;
    kind = $urandom_range(0, 99);
    dep  = $urandom_range(0, 255);
    for (int i = 0; i < WinCount; i++) begin
      if (kind < 5) begin
        word = '0;
      end else if (kind < 20) begin
        word = $urandom;
      end else if (kind < 30) begin
        word = ($urandom_range(0, 3) == 0) ? pixel_at_depth(dep) : '0;
      end else if (i == 0) begin
        word = pixel_at_depth(dep);
      end else if ($urandom_range(0, 7) == 0) begin
        word = '0;
      end else begin
        word = pixel_at_depth(dep + int'($urandom_range(0, 2 * spread)) - spread);
      end
      win[PixelW*(WinCount-1-i) +: PixelW] = word;
    end
    return win;
  endfunction

  // called and left at a falling edge
  task automatic send_window(input req_t win);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= win;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pixels.push_back(predict_pixel(win));
    windows_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (PipeLat + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BLUR_ENABLE) blur_on = data[0];
    else if (idx == CFG_DEPTH_TOL) tol_reg = data;
    @(negedge clk_i);
  endtask

  task automatic test_bypass_at_reset();
    send_window('0);
    send_window('1);
    send_window(window_of(32'h80C0_FFEE, 128, 0));
    send_window(random_window(20));
    drain_results();
  endtask

  task automatic test_default_tolerance_edges();
    write_reg(CFG_BLUR_ENABLE, EnableOn);
    send_window('0);
    send_window(window_of(32'h40A0_B0C0, 0, 8));
    send_window(window_of(32'h0000_0000, 20, 0));
    send_window('1);
    send_window(window_of(32'h0012_3456, 0, 2));
    send_window(window_of(32'h7E80_8080, 126, 1));
    send_window(window_of(32'h7F11_2233, 127, 0));
    send_window(window_of(32'h80FE_DCBA, 128, 3));
    send_window(window_of(32'h6455_AA55, 110, 0));
    send_window(window_of(32'h6455_AA55, 90, 0));
    send_window(window_of(32'h6401_0203, 111, 0));
    send_window(window_of(32'h6401_0203, 89, 0));
    send_window(window_of(32'h2100_8040, 34, 5));
    drain_results();
  endtask

  task automatic test_tolerance_extremes();
    write_reg(CFG_DEPTH_TOL, 8'd0);
    send_window(window_of(32'h5010_2030, 80, 2));
    send_window(window_of(32'h5010_2030, 81, 2));
    send_window(window_of(32'h5010_2030, 79, 6));
    drain_results();
    write_reg(CFG_DEPTH_TOL, 8'd255);
    send_window(window_of(32'hFF00_0000, 0, 0));
    send_window(window_of(32'h00FF_FFFF, 255, 0));
    send_window(window_of(32'hFFFF_FFFF, 0, 7));
    drain_results();
  endtask

  task automatic test_register_decode();
    // spare indexes must not disturb the registers
    write_reg(CfgIdxSpareA, 8'h00);
    write_reg(CfgIdxSpareB, 8'h03);
    send_window(window_of(32'h3344_5566, 200, 0));
    send_window(window_of(32'h0000_0000, 255, 0));
    drain_results();
    // only bit 0 of the enable write counts
    write_reg(CFG_BLUR_ENABLE, EnableOffHi);
    send_window(window_of(32'h3344_5566, 51, 0));
    drain_results();
    write_reg(CFG_BLUR_ENABLE, EnableOn);
    send_window(window_of(32'h3344_5566, 51, 0));
    drain_results();
  endtask

  task automatic run_random_phase(input int count, input int spread);
    for (int i = 0; i < count; i++) begin
      sender_calm   = (i < 30);
      receiver_calm = (i >= 30 && i < 60);
      if (i == count / 2) drain_results();
      send_window(random_window(spread));
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [7:0] tol;
    write_reg(CFG_DEPTH_TOL, DefaultTol);
    run_random_phase(200, 14);
    write_reg(CFG_DEPTH_TOL, 8'd0);
    run_random_phase(200, 2);
    write_reg(CFG_DEPTH_TOL, 8'd255);
    run_random_phase(200, 255);
    tol = $urandom_range(1, 254);
    write_reg(CFG_DEPTH_TOL, tol);
    run_random_phase(200, int'(tol) + 3);
    write_reg(CFG_BLUR_ENABLE, 8'h00);
    write_reg(CFG_DEPTH_TOL, 8'd77);
    run_random_phase(200, 20);
  endtask

  // result side: random stall before taking each result
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = receiver_calm ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    res_t exp_px;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $error("result without a pending request: out_pixel %h path_taken %0d",
               out_data_o.out_pixel, out_data_o.path_taken);
        errors_seen++;
      end else begin
        exp_px = pending_pixels.pop_front();
        results_checked++;
        path_hits[exp_px.path_taken]++;
        if (out_data_o.out_pixel !== exp_px.out_pixel) begin
          $error("out_pixel: expected %h, actual %h", exp_px.out_pixel, out_data_o.out_pixel);
          errors_seen++;
        end
        if (out_data_o.path_taken !== exp_px.path_taken) begin
          $error("path_taken: expected %0d, actual %0d",
                 exp_px.path_taken, out_data_o.path_taken);
          errors_seen++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == StallLimit) begin
      $display("timeout after %0d cycles without progress", StallLimit);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_BLUR_ENABLE;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    rst_ni        = 1'b0;
    blur_on       = 1'b0;
    tol_reg       = DefaultTol;
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_bypass_at_reset();
    test_default_tolerance_edges();
    test_tolerance_extremes();
    test_register_decode();
    test_random_traffic();

    $display("%0d windows sent, %0d results checked", windows_sent, results_checked);
    $display("paths seen: empty %0d, blended %0d, sharp %0d, bypass %0d",
             path_hits[PATH_EMPTY], path_hits[PATH_BLEND],
             path_hits[PATH_SHARP], path_hits[PATH_BYPASS]);
    if (errors_seen == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
